FILE: design/fcqg_pkg.sv
// ----------------------------------------------------------------------------
// fcqg_pkg
// Shared types and the fixed cost-ratio table of the quality governor.
// ----------------------------------------------------------------------------
package fcqg_pkg;

    localparam int RATIO_W  = 17;
    localparam int COST_W   = 16;
    localparam int LADDER_W = 20;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        KIND_MEASURE = 3'd0,
        KIND_ALLOC   = 3'd1,
        KIND_GRANT   = 3'd2,
        KIND_PIN     = 3'd3,
        KIND_TICK    = 3'd4,
        KIND_RESTORE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        REG_FILTER_WEIGHT = 3'd0,
        REG_TIGHTEN       = 3'd1,
        REG_RELAX         = 3'd2,
        REG_DWELL         = 3'd3,
        REG_RESERVED      = 3'd4,
        REG_BASE_COST     = 3'd5,
        REG_LADDERS       = 3'd6
    } cfg_reg_t;

    // Q1.16 cost ratio for a lever and a ladder position
    function automatic logic [RATIO_W-1:0] ratio_lookup(input logic [2:0] lever,
                                                        input logic [1:0] pos);
        logic [RATIO_W-1:0] r;
        r = 17'd65536;
        if (pos != 2'd0)
        begin
            case (lever)
                3'd0: r = (pos == 2'd1) ? 17'd60293 : 17'd56361;
                3'd1: r = (pos == 2'd1) ? 17'd58982 : 17'd53740;
                3'd2: r = (pos == 2'd1) ? 17'd56361 :
                          (pos == 2'd2) ? 17'd48497 : 17'd43254;
                3'd3: r = (pos == 2'd1) ? 17'd57672 : 17'd51118;
                3'd4: r = (pos == 2'd1) ? 17'd47186 : 17'd36045;
                default: r = 17'd65536;
            endcase
        end
        return r;
    endfunction

endpackage

FILE: design/frame_cost_quality_governor_core.sv
// ----------------------------------------------------------------------------
// frame_cost_quality_governor_core
// Steps quality levers down or back up from smoothed measured frame cost.
//
//  channel  | signals                         | content
//  s_*      | tvalid tready tdata[23:0] tuser | one request: kind, amount, pin
//  m_*      | tvalid tready tdata[71:0]       | one status result per request
//  cfg_*    | we index[2:0] data[19:0]        | register writes
//
// The time one request takes is set by one bit-serial multiplier and a
// bit-serial divider; tick with relax scan is the longest path, and other
// kinds take one prediction.
// Reset clears all state and loads register defaults.
// A new request is taken while the previous result waits on m_tready.
// ----------------------------------------------------------------------------
module frame_cost_quality_governor_core
    import fcqg_pkg::*;
#(
    parameter int LEVER_COUNT = 5,
    parameter int MAX_STEPS   = 4
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // amount[15:0], pin_flag[16]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // tightened[0] relaxed[1] lever_moved[4:2] from_step[6:5] to_step[8:7]
    // smoothed_cost[24:9] predicted_cost[40:25] all_at_floor[41]
    // at_reserved[42] pinned_overrun[58:43] lever_steps[68:59]
    output logic [71:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LADDER_W-1:0]  cfg_data
);

    localparam int LIDX_W = (LEVER_COUNT > 1) ? $clog2(LEVER_COUNT) : 1;
    localparam int CNT_W  = $clog2(LEVER_COUNT + 1);
    localparam int STEP_CAP = (MAX_STEPS < 4) ? MAX_STEPS : 4;
    localparam int PACK_N = (LEVER_COUNT < 5) ? LEVER_COUNT : 5;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_FILT2, S_FILT3, S_TCMP, S_RCMP, S_PSTART, S_PSEL,
        S_PACC, S_PBASE, S_PEND, S_SSEL, S_SMUL, S_SDIV, S_SCMP, S_OUT, S_MUL
    } state_t;

    state_t state_reg, ret_reg;

    logic [16:0] weight_reg;
    logic [15:0] tighten_reg, relax_m_reg, dwell_reg, resmin_reg, base_reg;
    logic [LADDER_W-1:0] ladders_reg;

    logic [1:0]  pos_reg [LEVER_COUNT];
    logic [15:0] smoothed_reg, alloc_reg, pred_reg, overrun_reg;
    logic        seen_reg, relax_ok_reg, pinned_reg;
    logic [31:0] frame_reg, last_relax_reg, rm_prod_reg;

    logic [2:0]  kind_reg;
    logic [15:0] amount_reg;
    logic        pin_reg;

    logic        tight_reg, relx_reg;
    logic [2:0]  moved_reg;
    logic [1:0]  from_reg, to_reg;
    logic        scan_reg, m_valid_reg;
    logic [71:0] m_data_reg;

    logic [16:0] mul_a_reg, mul_b_reg, factor_reg, cur_reg;
    logic [33:0] acc_reg, tmp_reg, num_reg;
    logic [16:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [CNT_W-1:0] idx_reg;

    function automatic logic is_declared(input logic [2:0] i);
        logic [3:0] nib;
        nib = 4'(ladders_reg >> {i, 2'b00});
        return (i < 3'd5) && nib[3];
    endfunction

    function automatic logic [1:0] last_pos(input logic [2:0] i);
        logic [3:0] nib;
        logic [2:0] n;
        nib = 4'(ladders_reg >> {i, 2'b00});
        n = nib[2:0];
        if (n > 3'(STEP_CAP))
        begin
            n = 3'(STEP_CAP);
        end
        if (i >= 3'd5 || n == 3'd0)
        begin
            return 2'd0;
        end
        return 2'(n - 3'd1);
    endfunction

    function automatic logic [16:0] lever_ratio(input logic [2:0] i, input logic [1:0] p);
        logic [1:0] lp;
        lp = last_pos(i);
        return ratio_lookup(i, (p > lp) ? lp : p);
    endfunction

    // read port of the position array shared by the prediction and the relax scan
    logic [CNT_W-1:0]  scan_k;
    logic [CNT_W-1:0]  rd_cnt;
    logic [2:0]        rd_lever;
    logic [1:0]        rd_pos;
    assign scan_k   = idx_reg - CNT_W'(1);
    assign rd_cnt   = (state_reg == S_PSEL) ? idx_reg : scan_k;
    assign rd_lever = 3'(rd_cnt);
    assign rd_pos   = pos_reg[rd_cnt[LIDX_W-1:0]];

    logic [16:0] w_cl;
    assign w_cl = (weight_reg < 17'd655)   ? 17'd655 :
                  (weight_reg > 17'd65536) ? 17'd65536 : weight_reg;

    logic        t_found;
    logic [2:0]  t_idx;
    logic        floor_all;
    logic [9:0]  packed_pos;
    always_comb
    begin
        t_found = 1'b0;
        t_idx = 3'd0;
        floor_all = 1'b1;
        packed_pos = '0;
        for (int i = LEVER_COUNT - 1; i >= 0; i--)
        begin
            if (is_declared(3'(i)) && pos_reg[i] < last_pos(3'(i)))
            begin
                t_found = 1'b1;
                t_idx = 3'(i);
                floor_all = 1'b0;
            end
        end
        for (int i = 0; i < PACK_N; i++)
        begin
            packed_pos[2*i +: 2] = pos_reg[i];
        end
    end

    logic        dwell_ok;
    logic [32:0] dwell_end;
    assign dwell_end = {1'b0, last_relax_reg} + 33'(dwell_reg);
    assign dwell_ok  = {1'b0, frame_reg} >= dwell_end;

    logic [33:0] rnd_sum;
    assign rnd_sum = acc_reg + 34'd32768;

    logic [17:0] div_shift;
    logic [18:0] div_trial;
    assign div_shift = {rem_reg, num_reg[33]};
    assign div_trial = {1'b0, div_shift} - {2'b00, cur_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            weight_reg <= 17'd6554;
            tighten_reg <= 16'd4096;
            relax_m_reg <= 16'd3482;
            dwell_reg <= 16'd30;
            resmin_reg <= 16'd0;
            base_reg <= 16'd256;
            ladders_reg <= 20'd769211;
            for (int i = 0; i < LEVER_COUNT; i++)
            begin
                pos_reg[i] <= 2'd0;
            end
            smoothed_reg <= '0;
            alloc_reg <= '0;
            pred_reg <= '0;
            overrun_reg <= '0;
            seen_reg <= 1'b0;
            relax_ok_reg <= 1'b0;
            pinned_reg <= 1'b0;
            frame_reg <= '0;
            last_relax_reg <= '0;
            rm_prod_reg <= '0;
            kind_reg <= '0;
            amount_reg <= '0;
            pin_reg <= 1'b0;
            tight_reg <= 1'b0;
            relx_reg <= 1'b0;
            moved_reg <= '0;
            from_reg <= '0;
            to_reg <= '0;
            scan_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg <= '0;
            mul_a_reg <= '0;
            mul_b_reg <= '0;
            factor_reg <= '0;
            cur_reg <= '0;
            acc_reg <= '0;
            tmp_reg <= '0;
            num_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (m_valid_reg && m_tready && state_reg != S_OUT)
            begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we && cfg_index <= REG_LADDERS)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FILTER_WEIGHT: weight_reg <= cfg_data[16:0];
                    REG_TIGHTEN:       tighten_reg <= cfg_data[15:0];
                    REG_RELAX:         relax_m_reg <= cfg_data[15:0];
                    REG_DWELL:         dwell_reg <= cfg_data[15:0];
                    REG_RESERVED:      resmin_reg <= cfg_data[15:0];
                    REG_BASE_COST:     base_reg <= cfg_data[15:0];
                    REG_LADDERS:       ladders_reg <= cfg_data;
                    default:           ladders_reg <= ladders_reg;
                endcase
                for (int i = 0; i < LEVER_COUNT; i++)
                begin
                    pos_reg[i] <= 2'd0;
                end
                relax_ok_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg <= s_tuser;
                        amount_reg <= s_tdata[15:0];
                        pin_reg <= s_tdata[16];
                        tight_reg <= 1'b0;
                        relx_reg <= 1'b0;
                        moved_reg <= '0;
                        from_reg <= '0;
                        to_reg <= '0;
                        overrun_reg <= '0;
                        scan_reg <= 1'b0;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    state_reg <= S_PSTART;
                    case (kind_reg)
                        KIND_MEASURE:
                        begin
                            if (!seen_reg)
                            begin
                                smoothed_reg <= amount_reg;
                                seen_reg <= 1'b1;
                            end
                            else
                            begin
                                mul_a_reg <= w_cl;
                                mul_b_reg <= {1'b0, amount_reg};
                                acc_reg <= '0;
                                cnt_reg <= 6'd17;
                                ret_reg <= S_FILT2;
                                state_reg <= S_MUL;
                            end
                        end
                        KIND_ALLOC:   alloc_reg <= amount_reg;
                        KIND_GRANT:   relax_ok_reg <= 1'b1;
                        KIND_PIN:     pinned_reg <= pin_reg;
                        KIND_RESTORE:
                        begin
                            for (int i = 0; i < LEVER_COUNT; i++)
                            begin
                                pos_reg[i] <= 2'd0;
                            end
                            relax_ok_reg <= 1'b0;
                        end
                        KIND_TICK:
                        begin
                            frame_reg <= frame_reg + 32'd1;
                            if (pinned_reg)
                            begin
                                overrun_reg <= (smoothed_reg > alloc_reg) ?
                                               smoothed_reg - alloc_reg : 16'd0;
                            end
                            else if (alloc_reg != 16'd0 && seen_reg)
                            begin
                                mul_a_reg <= {1'b0, alloc_reg};
                                mul_b_reg <= {1'b0, tighten_reg};
                                acc_reg <= '0;
                                cnt_reg <= 6'd17;
                                ret_reg <= S_TCMP;
                                state_reg <= S_MUL;
                            end
                        end
                        default: state_reg <= S_PSTART;
                    endcase
                end
                S_MUL:
                begin
                    acc_reg <= {acc_reg[32:0], 1'b0} + (mul_b_reg[16] ? 34'(mul_a_reg) : 34'd0);
                    mul_b_reg <= {mul_b_reg[15:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_FILT2:
                begin
                    tmp_reg <= acc_reg;
                    mul_a_reg <= 17'd65536 - w_cl;
                    mul_b_reg <= {1'b0, smoothed_reg};
                    acc_reg <= '0;
                    cnt_reg <= 6'd17;
                    ret_reg <= S_FILT3;
                    state_reg <= S_MUL;
                end
                S_FILT3:
                begin
                    smoothed_reg <= 16'((tmp_reg + rnd_sum) >> 16);
                    state_reg <= S_PSTART;
                end
                S_TCMP:
                begin
                    state_reg <= S_PSTART;
                    if ({6'd0, smoothed_reg, 12'd0} > acc_reg)
                    begin
                        if (t_found)
                        begin
                            tight_reg <= 1'b1;
                            moved_reg <= t_idx;
                            from_reg <= pos_reg[t_idx[LIDX_W-1:0]];
                            to_reg <= pos_reg[t_idx[LIDX_W-1:0]] + 2'd1;
                            pos_reg[t_idx[LIDX_W-1:0]] <= pos_reg[t_idx[LIDX_W-1:0]] + 2'd1;
                        end
                    end
                    else if (relax_ok_reg && dwell_ok)
                    begin
                        mul_a_reg <= {1'b0, alloc_reg};
                        mul_b_reg <= {1'b0, relax_m_reg};
                        acc_reg <= '0;
                        cnt_reg <= 6'd17;
                        ret_reg <= S_RCMP;
                        state_reg <= S_MUL;
                    end
                end
                S_RCMP:
                begin
                    rm_prod_reg <= acc_reg[31:0];
                    scan_reg <= 1'b1;
                    state_reg <= S_PSTART;
                end
                S_PSTART:
                begin
                    if (seen_reg)
                    begin
                        pred_reg <= smoothed_reg;
                        state_reg <= S_PEND;
                    end
                    else
                    begin
                        factor_reg <= 17'd65536;
                        idx_reg <= '0;
                        state_reg <= S_PSEL;
                    end
                end
                S_PSEL:
                begin
                    if (idx_reg == CNT_W'(LEVER_COUNT))
                    begin
                        mul_a_reg <= {1'b0, base_reg};
                        mul_b_reg <= factor_reg;
                        acc_reg <= '0;
                        cnt_reg <= 6'd17;
                        ret_reg <= S_PBASE;
                        state_reg <= S_MUL;
                    end
                    else if (is_declared(rd_lever))
                    begin
                        mul_a_reg <= factor_reg;
                        mul_b_reg <= lever_ratio(rd_lever, rd_pos);
                        acc_reg <= '0;
                        cnt_reg <= 6'd17;
                        ret_reg <= S_PACC;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_PACC:
                begin
                    factor_reg <= rnd_sum[32:16];
                    idx_reg <= idx_reg + CNT_W'(1);
                    state_reg <= S_PSEL;
                end
                S_PBASE:
                begin
                    pred_reg <= (rnd_sum[33:16] > 18'd65535) ? 16'hFFFF : rnd_sum[31:16];
                    state_reg <= S_PEND;
                end
                S_PEND:
                begin
                    if (scan_reg)
                    begin
                        scan_reg <= 1'b0;
                        idx_reg <= CNT_W'(LEVER_COUNT);
                        state_reg <= S_SSEL;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SSEL:
                begin
                    if (idx_reg == '0)
                    begin
                        state_reg <= S_PSTART;
                    end
                    else if (!is_declared(rd_lever) || rd_pos == 2'd0)
                    begin
                        idx_reg <= scan_k;
                    end
                    else
                    begin
                        cur_reg <= lever_ratio(rd_lever, rd_pos);
                        mul_a_reg <= {1'b0, pred_reg};
                        mul_b_reg <= lever_ratio(rd_lever, rd_pos - 2'd1);
                        acc_reg <= '0;
                        cnt_reg <= 6'd17;
                        ret_reg <= S_SMUL;
                        state_reg <= S_MUL;
                    end
                end
                S_SMUL:
                begin
                    num_reg <= acc_reg + 34'(cur_reg[16:1]);
                    rem_reg <= '0;
                    cnt_reg <= 6'd34;
                    state_reg <= S_SDIV;
                end
                S_SDIV:
                begin
                    if (!div_trial[18])
                    begin
                        rem_reg <= div_trial[16:0];
                        num_reg <= {num_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_shift[16:0];
                        num_reg <= {num_reg[32:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_SCMP;
                    end
                end
                S_SCMP:
                begin
                    if ({num_reg[19:0], 12'd0} <= rm_prod_reg && num_reg[33:20] == '0)
                    begin
                        relx_reg <= 1'b1;
                        moved_reg <= rd_lever;
                        from_reg <= rd_pos;
                        to_reg <= rd_pos - 2'd1;
                        pos_reg[scan_k[LIDX_W-1:0]] <= rd_pos - 2'd1;
                        relax_ok_reg <= 1'b0;
                        last_relax_reg <= frame_reg;
                        state_reg <= S_PSTART;
                    end
                    else
                    begin
                        idx_reg <= scan_k;
                        state_reg <= S_SSEL;
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg <= {3'd0, packed_pos, overrun_reg,
                                       (alloc_reg <= resmin_reg), floor_all,
                                       pred_reg, smoothed_reg, to_reg, from_reg,
                                       moved_reg, relx_reg, tight_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("tighten and relax in one result");

    a_move_changes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[0] || m_tdata[1])) |-> (m_tdata[6:5] != m_tdata[8:7]))
        else $error("moved lever kept its position");

    a_take_once: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_SDIV) |-> (cnt_reg != 6'd0))
        else $error("serial unit ran past its count");

endmodule
